// File: rtl/binned_running_mean_variance_defines.svh
// Assertion macros shared by the checker.
`ifndef BINNED_RUNNING_MEAN_VARIANCE_DEFINES_SVH
`define BINNED_RUNNING_MEAN_VARIANCE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define BRMV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define BRMV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/brmv_pkg.sv
package brmv_pkg;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned DEV_W    = 64;
    localparam int unsigned DEVO_W   = 63;
    localparam int unsigned BIN_W    = 8;
    localparam int unsigned CFG_W    = 9;
    localparam logic [CFG_W-1:0] BINS_RESET = 9'd256;
    localparam logic [DEV_W-1:0] DEV_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic {
        ST_OK    = 1'b0,
        ST_RANGE = 1'b1
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RDW,
        S_CHK,
        S_DIV,
        S_MEAN,
        S_MUL,
        S_ACC,
        S_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic div_start;
        logic mean;
        logic mul;
        logic acc;
        logic wr;
        logic res_ok;
        logic res_bad;
        logic out_ld;
    } t_ctl;

    typedef struct packed {
        logic in_range;
        logic is_add;
        logic div_done;
    } t_sts;

    typedef struct packed {
        logic                    command;
        logic signed [SAMPLE_W-1:0] sample;
        logic [BIN_W-1:0]        bin_index;
    } t_in;

    typedef struct packed {
        logic                    status;
        logic signed [SAMPLE_W-1:0] bin_mean;
        logic [DEVO_W-1:0]       bin_deviation_sum;
        logic [COUNT_W-1:0]      bin_samples;
    } t_out;
endpackage

// File: rtl/brmv_if.sv
interface brmv_in_if;
    logic            valid;
    logic            ready;
    brmv_pkg::t_in   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface brmv_out_if;
    logic            valid;
    logic            ready;
    brmv_pkg::t_out  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/brmv_div.sv
module brmv_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [31:0] i_den,
    output logic [32:0] o_quo,
    output logic        o_done
);
    import brmv_pkg::*;

    logic [32:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [33:0] w_sh;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_sh   = {r_rem, r_quo[32]};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {2'b00, r_den}) begin
                n_rem = 33'(w_sh - {2'b00, r_den});
                n_quo = {r_quo[31:0], 1'b1};
            end else begin
                n_rem = w_sh[32:0];
                n_quo = {r_quo[31:0], 1'b0};
            end
            n_cnt = 6'(r_cnt + 6'd1);
            if (r_cnt == 6'd32) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_busy && (r_cnt == 6'd32);
endmodule

// File: rtl/brmv_ctrl.sv
module brmv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  logic            i_clr_done,
    input  brmv_pkg::t_sts  i_sts,
    output brmv_pkg::t_ctl  o_ctl
);
    import brmv_pkg::*;

    t_state r_state, n_state;
    logic   r_ov, n_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ov       = r_ov;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_clr_done;
                if (i_in_valid && i_clr_done) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_ctl.rd = 1'b1;
                n_state  = S_RDW;
            end
            S_RDW: n_state = S_CHK;
            S_CHK: begin
                if (!i_sts.in_range) begin
                    o_ctl.res_bad = 1'b1;
                    n_state       = S_OUT;
                end else if (i_sts.is_add) begin
                    o_ctl.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_ctl.res_ok = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_DIV: if (i_sts.div_done) begin
                n_state = S_MEAN;
            end
            S_MEAN: begin
                o_ctl.mean = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_ctl.acc = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_ctl.wr     = 1'b1;
                o_ctl.res_ok = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: if (!r_ov || i_out_ready) begin
                o_ctl.out_ld = 1'b1;
                n_ov         = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ov;
endmodule

// File: rtl/brmv_dp.sv
module brmv_dp #(
    parameter int unsigned NUM_BINS = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brmv_pkg::t_ctl  i_ctl,
    input  brmv_pkg::t_in   i_in,
    input  logic [8:0]      i_bins,
    output brmv_pkg::t_sts  o_sts,
    output logic            o_clr_done,
    output brmv_pkg::t_out  o_res
);
    import brmv_pkg::*;

    localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    logic [COUNT_W+SAMPLE_W+DEV_W-1:0] r_mem [NUM_BINS];
    logic [COUNT_W+SAMPLE_W+DEV_W-1:0] r_rdata;

    logic [AW:0]       r_clr;
    logic              r_cmd;
    logic signed [31:0] r_x;
    logic [BIN_W-1:0]  r_bin;
    logic              r_ok;
    logic [31:0]       r_cnt;
    logic signed [31:0] r_mean;
    logic [63:0]       r_dev;
    logic              r_neg;
    logic [32:0]       r_dmag;
    logic [32:0]       r_dmag2;
    logic [63:0]       r_prod;
    logic [31:0]       w_k;
    logic signed [32:0] w_delta;
    logic signed [32:0] w_mnew;
    logic signed [32:0] w_d2;
    logic [32:0]       w_quo;
    logic              w_done;
    logic [63:0]       w_room;
    logic [AW-1:0]     w_addr;
    t_out              r_res;

    // count and mean come straight from the bin read, held until the next read
    assign w_k = (r_rdata[127:96] == COUNT_MAX) ? r_rdata[127:96]
        : 32'(r_rdata[127:96] + 32'd1);
    assign w_delta = 33'(r_x) - 33'($signed(r_rdata[95:64]));
    assign w_mnew = r_neg ? 33'(r_mean) - $signed(w_quo) : 33'(r_mean) + $signed(w_quo);
    assign w_d2 = 33'(r_x) - w_mnew;
    assign w_room = DEV_MAX - r_dev;
    assign w_addr = AW'(r_bin);

    brmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (w_delta[32] ? 33'(-w_delta) : w_delta),
        .i_den   (w_k),
        .o_quo   (w_quo),
        .o_done  (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_clr != (AW+1)'(NUM_BINS)) begin
            r_clr <= (AW+1)'(r_clr + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr != (AW+1)'(NUM_BINS)) begin
            r_mem[r_clr[AW-1:0]] <= '0;
        end else if (i_ctl.wr) begin
            r_mem[w_addr] <= {r_cnt, r_mean, r_dev};
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd <= i_in.command;
            r_x   <= i_in.sample;
            r_bin <= i_in.bin_index;
            r_ok  <= ({1'b0, i_in.bin_index} < i_bins)
                && (32'(i_in.bin_index) < 32'(NUM_BINS));
        end
        if (i_ctl.div_start) begin
            r_cnt   <= r_rdata[127:96];
            r_mean  <= r_rdata[95:64];
            r_dev   <= r_rdata[63:0];
            r_neg   <= w_delta[32];
            r_dmag  <= w_delta[32] ? 33'(-w_delta) : w_delta;
        end
        if (i_ctl.res_ok && !i_ctl.wr) begin
            r_cnt  <= r_rdata[127:96];
            r_mean <= r_rdata[95:64];
            r_dev  <= r_rdata[63:0];
        end
        if (i_ctl.mean) begin
            r_cnt   <= w_k;
            r_mean  <= w_mnew[31:0];
            r_dmag2 <= w_d2[32] ? 33'(-w_d2) : w_d2;
        end
        if (i_ctl.mul) begin
            r_prod <= 64'(r_dmag * r_dmag2);
        end
        if (i_ctl.acc) begin
            r_dev <= (r_prod > w_room) ? DEV_MAX : 64'(r_dev + r_prod);
        end
        if (i_ctl.res_bad) begin
            r_res <= '{status: ST_RANGE, bin_mean: '0, bin_deviation_sum: '0,
                bin_samples: '0};
        end
    end

    always_comb begin
        o_res = r_res;
        if (!r_ok) begin
            o_res = '0;
            o_res.status = ST_RANGE;
        end else begin
            o_res.status = ST_OK;
            o_res.bin_mean = r_mean;
            o_res.bin_deviation_sum = r_dev[62:0];
            o_res.bin_samples = r_cnt;
        end
    end

    assign o_sts.in_range = r_ok;
    assign o_sts.is_add   = (r_cmd == CMD_ADD);
    assign o_sts.div_done = w_done;
    assign o_clr_done     = (r_clr == (AW+1)'(NUM_BINS));
endmodule

// File: rtl/binned_running_mean_variance.sv
// Add: S_RD, S_RDW, S_CHK, S_DIV, S_MEAN, S_MUL, S_ACC, S_WR, then S_OUT.
// Throughput: one request at a time; an add is paced by a 33-step radix-2 divider.
// Read: S_RD, S_RDW, S_CHK, then the output handoff in S_OUT.
// Reset: synchronous active low; a clearing pass that zeroes every bin follows,
// during which no request is taken. The bins-in-use register r_bins resets to 256.
module binned_running_mean_variance #(
    parameter int unsigned NUM_BINS = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   cfg_we,
    input  logic [8:0]             cfg_wdata,
    brmv_in_if.sink                in_ch,
    brmv_out_if.source             out_ch
);
    import brmv_pkg::*;

    logic [CFG_W-1:0] r_bins;
    logic             w_clr_done;
    t_ctl             w_ctl;
    t_sts             w_sts;
    t_out             w_res;
    t_out             r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= BINS_RESET;
        end else if (cfg_we) begin
            r_bins <= cfg_wdata;
        end
    end

    brmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_clr_done  (w_clr_done),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    brmv_dp #(.NUM_BINS(NUM_BINS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_in       (in_ch.payload),
        .i_bins     (r_bins),
        .o_sts      (w_sts),
        .o_clr_done (w_clr_done),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_ld) begin
            r_out <= w_res;
        end
    end

    assign out_ch.payload = r_out;
endmodule

// File: rtl/brmv_checker.sv
`include "binned_running_mean_variance_defines.svh"

module brmv_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input brmv_pkg::t_out out_payload
);
    import brmv_pkg::*;

    `BRMV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "result dropped or changed while stalled")
    `BRMV_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, out_valid && out_payload.status == ST_RANGE, out_payload.bin_samples == '0 && out_payload.bin_mean == '0, "rejected request carries data")
    `BRMV_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, in_valid && in_ready, !in_ready, "second request accepted too soon")
    `BRMV_ASSERT_IMP(a_ok_count, i_clk, i_rst_n, out_valid && out_payload.status == ST_OK && out_payload.bin_deviation_sum != '0, out_payload.bin_samples > 32'd1, "deviation without two samples")
endmodule

bind binned_running_mean_variance brmv_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);
